[src/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the ring modulator checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked while reset is high
`define RMS_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rms assertion failed");

// Next-cycle implication, masked while reset is high
`define RMS_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rms assertion failed");

// Next-cycle implication, never masked (for reset behavior)
`define RMS_ASSERT_ALWAYS_NXT(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("rms assertion failed");

`endif

[src/rms_pkg.sv]
// ----------------------------------------------------------------------------
// rms_pkg
// Widths, reset values, constants and shared types of the ring modulator.
// ----------------------------------------------------------------------------
package rms_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int PHASE_W   = 32;
  localparam int PRODUCT_W = 32;
  localparam int MAG_W     = 15;

  localparam logic [PHASE_W-1:0] PHASE_STEP_RESET = 32'd39370534;

  // pi/2 in Q30
  localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;

  // Taylor term divisors (2i)(2i+1) for i = 1..7
  localparam logic [7:0] TAYLOR_DIV [7] = '{8'd6, 8'd20, 8'd42, 8'd72, 8'd110,
                                            8'd156, 8'd210};

  localparam logic [MAG_W-1:0] Q15_MAX = 15'd32767;

  // Fixed part of one queued item
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic [1:0]                 quadrant;
  } rms_tag_t;

endpackage

[src/rms_ifs.sv]
// ----------------------------------------------------------------------------
// rms_ifs
// Stream channels of the ring modulator: samples in, samples out, config.
// ----------------------------------------------------------------------------
interface rms_din_if import rms_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample_in;
  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

interface rms_dout_if import rms_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample_out;
  modport source (output valid, output sample_out, input ready);
  modport sink   (input valid, input sample_out, output ready);
endinterface

interface rms_cfg_if import rms_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [PHASE_W-1:0] phase_step;
  modport source (output valid, output phase_step, input ready);
  modport sink   (input valid, input phase_step, output ready);
endinterface

[src/rms_front.sv]
// ----------------------------------------------------------------------------
// rms_front
// Accepts samples, runs the phase accumulator and classifies each sample's
// carrier phase into quadrant and quarter-wave position.
// ----------------------------------------------------------------------------
module rms_front import rms_pkg::*; #(
  parameter int SINE_TABLE_BITS = 10
) (
  input  logic                       clk,
  input  logic                       rst,
  rms_din_if.sink                    din,
  rms_cfg_if.sink                    cfg,
  output logic                       push_valid,
  input  logic                       push_ready,
  output rms_tag_t                   push_tag,
  output logic [SINE_TABLE_BITS-3:0] push_pos
);

  logic [PHASE_W-1:0]         phase_step;
  logic [PHASE_W-1:0]         carrier_phase;
  logic [SINE_TABLE_BITS-1:0] idx;

  assign cfg.ready = 1'b1;
  assign din.ready = push_ready;
  assign push_valid = din.valid;

  // Carrier uses the phase before this item advances it
  assign idx               = carrier_phase[PHASE_W-1 -: SINE_TABLE_BITS];
  assign push_tag.sample   = din.sample_in;
  assign push_tag.quadrant = idx[SINE_TABLE_BITS-1 -: 2];
  assign push_pos          = idx[SINE_TABLE_BITS-3:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_step    <= PHASE_STEP_RESET;
      carrier_phase <= '0;
    end else begin
      if (cfg.valid) begin
        phase_step <= cfg.phase_step;
      end
      if (din.valid && push_ready) begin
        carrier_phase <= carrier_phase + phase_step;
      end
    end
  end

endmodule

[src/rms_queue.sv]
// ----------------------------------------------------------------------------
// rms_queue
// Two-entry queue between the front and back parts.
// ----------------------------------------------------------------------------
module rms_queue #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push_valid,
  output logic         push_ready,
  input  logic [W-1:0] push_data,
  output logic         pop_valid,
  input  logic         pop_ready,
  output logic [W-1:0] pop_data
);

  logic [W-1:0] mem [2];
  logic         wr_ptr;
  logic         rd_ptr;
  logic [1:0]   count;
  logic         do_push;
  logic         do_pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_data   = mem[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

[src/rms_back.sv]
// ----------------------------------------------------------------------------
// rms_back
// Quarter-wave sine ROM lookup, multiply and Q15 rescale, three stages
// with an output register that holds under backpressure.
// ----------------------------------------------------------------------------
module rms_back import rms_pkg::*; #(
  parameter int SINE_TABLE_BITS = 10
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       pop_valid,
  output logic                       pop_ready,
  input  rms_tag_t                   pop_tag,
  input  logic [SINE_TABLE_BITS-3:0] pop_pos,
  rms_dout_if.source                 dout
);

  localparam int QLEN = 1 << (SINE_TABLE_BITS - 2);
  localparam int AW   = SINE_TABLE_BITS - 1;

  typedef logic [MAG_W-1:0] rom_t [QLEN+1];

  // Taylor series of sin over the first quarter wave, Q30 scaled to Q15
  function automatic rom_t build_rom();
    rom_t               r;
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic [63:0]        q15;
    for (int k = 0; k <= QLEN; k++) begin
      x    = (PI_HALF_Q30 * 64'(k)) / 64'(QLEN);
      x2   = (x * x) >> 30;
      term = x;
      sum  = $signed(x);
      for (int i = 1; i <= 7; i++) begin
        term = (term * x2) >> 30;
        term = term / 64'(TAYLOR_DIV[i-1]);
        if (i % 2 == 1) begin
          sum = sum - $signed(term);
        end else begin
          sum = sum + $signed(term);
        end
      end
      if (sum < 0) begin
        sum = '0;
      end
      q15 = ($unsigned(sum) * 64'd32767 + (64'd1 << 29)) >> 30;
      if (q15 > 64'(Q15_MAX)) begin
        q15 = 64'(Q15_MAX);
      end
      r[k] = q15[MAG_W-1:0];
    end
    return r;
  endfunction

  localparam rom_t SINE_ROM = build_rom();

  logic [AW-1:0]               rom_addr;
  logic                        s1_valid;
  logic signed [SAMPLE_W-1:0]  s1_sample;
  logic                        s1_neg;
  logic [MAG_W-1:0]            s1_mag;
  logic signed [SAMPLE_W-1:0]  carrier;
  logic                        s2_valid;
  logic signed [PRODUCT_W-1:0] s2_prod;
  logic signed [PRODUCT_W-1:0] biased;
  logic                        s3_valid;
  logic signed [SAMPLE_W-1:0]  s3_data;
  logic                        s1_ready;
  logic                        s2_ready;
  logic                        s3_ready;

  assign s3_ready  = !s3_valid || dout.ready;
  assign s2_ready  = !s2_valid || s3_ready;
  assign s1_ready  = !s1_valid || s2_ready;
  assign pop_ready = s1_ready;

  // Odd quadrants run the quarter wave backward
  assign rom_addr = pop_tag.quadrant[0] ? (AW'(QLEN) - {1'b0, pop_pos}) : {1'b0, pop_pos};

  assign carrier = s1_neg ? -$signed({1'b0, s1_mag}) : $signed({1'b0, s1_mag});

  // Bias negatives so the arithmetic shift truncates toward zero
  assign biased = s2_prod + (s2_prod[PRODUCT_W-1] ? 32'sd32767 : 32'sd0);

  always_ff @(posedge clk) begin
    if (s1_ready) begin
      s1_mag    <= SINE_ROM[rom_addr];
      s1_sample <= pop_tag.sample;
      s1_neg    <= pop_tag.quadrant[1];
    end
    if (s2_ready) begin
      s2_prod <= s1_sample * carrier;
    end
    if (s3_ready) begin
      s3_data <= biased[30:15];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid <= pop_valid;
      end
      if (s2_ready) begin
        s2_valid <= s1_valid;
      end
      if (s3_ready) begin
        s3_valid <= s2_valid;
      end
    end
  end

  assign dout.valid      = s3_valid;
  assign dout.sample_out = s3_data;

endmodule

[src/ring_modulator_sine_carrier.sv]
// ----------------------------------------------------------------------------
// ring_modulator_sine_carrier
// Ring modulator: each PCM sample times a sine carrier from a phase
// accumulator and a quarter-wave Q15 sine ROM.
//
//   channel  dir  payload               handshake
//   din      in   sample_in  s16        valid/ready
//   dout     out  sample_out s16        valid/ready
//   cfg      in   phase_step u32        valid/ready, ready always high
//
// One sample per cycle while dout takes results; an accepted sample is written
// to the queue, then passes the ROM read, multiply and rescale registers to dout.
// A stalled dout holds its result; the pipeline and two-entry queue fill
// before din drops ready. Synchronous reset clears the phase to zero and
// loads the default step; no clearing pass.
// ----------------------------------------------------------------------------
module ring_modulator_sine_carrier import rms_pkg::*; #(
  parameter int SINE_TABLE_BITS = 10
) (
  input  logic        clk,
  input  logic        rst,
  rms_din_if.sink     din,
  rms_dout_if.source  dout,
  rms_cfg_if.sink     cfg
);

  localparam int POS_W = SINE_TABLE_BITS - 2;
  localparam int QW    = $bits(rms_tag_t) + POS_W;

  logic             push_valid;
  logic             push_ready;
  rms_tag_t         push_tag;
  logic [POS_W-1:0] push_pos;
  logic             pop_valid;
  logic             pop_ready;
  logic [QW-1:0]    pop_data;
  rms_tag_t         pop_tag;
  logic [POS_W-1:0] pop_pos;

  rms_front #(.SINE_TABLE_BITS(SINE_TABLE_BITS)) u_front (
    .clk        (clk),
    .rst        (rst),
    .din        (din),
    .cfg        (cfg),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_tag   (push_tag),
    .push_pos   (push_pos)
  );

  rms_queue #(.W(QW)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  ({push_tag, push_pos}),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  assign pop_tag = pop_data[QW-1 -: $bits(rms_tag_t)];
  assign pop_pos = pop_data[POS_W-1:0];

  rms_back #(.SINE_TABLE_BITS(SINE_TABLE_BITS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_tag   (pop_tag),
    .pop_pos   (pop_pos),
    .dout      (dout)
  );

endmodule

[src/rms_checker.sv]
// ----------------------------------------------------------------------------
// rms_checker
// Port-level checks of the ring modulator, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rms_checker import rms_pkg::*; (
  input logic                       clk,
  input logic                       rst,
  input logic                       din_ready,
  input logic                       dout_valid,
  input logic                       dout_ready,
  input logic signed [SAMPLE_W-1:0] dout_data
);

  // Hold a stalled result
  `RMS_ASSERT_NXT(a_out_hold, clk, rst, dout_valid && !dout_ready, dout_valid && $stable(dout_data))

  // Drop results on reset
  `RMS_ASSERT_ALWAYS_NXT(a_rst_empty, clk, rst, !dout_valid)

  // Carrier magnitude stays below full scale, so the minimum code never shows
  `RMS_ASSERT_IMP(a_no_min, clk, rst, dout_valid, dout_data != 16'sh8000)

  // Input backpressure only follows a stalled output
  `RMS_ASSERT_IMP(a_din_stall, clk, rst, !din_ready, $past(dout_valid && !dout_ready))

  // Handshake controls stay known out of reset
  `RMS_ASSERT_IMP(a_ctrl_known, clk, rst, 1'b1, !$isunknown(din_ready) && !$isunknown(dout_valid))

endmodule

bind ring_modulator_sine_carrier rms_checker u_rms_checker (
  .clk        (clk),
  .rst        (rst),
  .din_ready  (din.ready),
  .dout_valid (dout.valid),
  .dout_ready (dout.ready),
  .dout_data  (dout.sample_out)
);
